FILE: hdl/scfa_pkg.sv
package scfa_pkg;

  // Fixed field widths.
  localparam int IdxW = 11;
  localparam int CntW = 12;
  localparam int ReqW = 16;
  localparam int ClsW = 4;
  localparam int OffW = 16;
  localparam int UsedW = 17;

  // Page and class geometry.
  localparam int PageBytes = 65536;
  localparam int MinClassBytes = 32;
  localparam int MaxClassBytes = 16384;
  localparam int MinShift = 5;
  localparam int ClassCount = 10;
  localparam int StackDepth = 2048;
  localparam int ShiftW = 5;

  // Opcodes of an input transaction.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  // Reset value of the stocked class register.
  localparam logic [ClsW-1:0] StockedReset = 4'd1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SIZE = 2'd1,
    STATUS_NO_SLOT  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  // One stack operation per cycle: a pop, a push, or nothing.
  typedef struct packed {
    logic            pop;
    logic            push;
    logic [IdxW-1:0] slot;
  } stack_cmd_t;

  // Result of the size class lookup.
  typedef struct packed {
    logic            found;
    logic [ClsW-1:0] cls;
  } class_enc_t;

  // Register values past the last class saturate to the last class.
  function automatic logic [ClsW-1:0] effective_class(input logic [ClsW-1:0] k);
    logic [ClsW-1:0] r;
    r = (k < ClsW'(ClassCount)) ? k : ClsW'(ClassCount - 1);
    return r;
  endfunction

  // Slots in one page for a class, which is at most the stack depth.
  function automatic logic [CntW-1:0] slots_per_page(input logic [ClsW-1:0] k);
    logic [CntW-1:0] r;
    r = CntW'(StackDepth) >> k;
    return r;
  endfunction

  // Byte size of a class.
  function automatic logic [UsedW-1:0] class_bytes(input logic [ClsW-1:0] k);
    logic [UsedW-1:0] r;
    r = UsedW'(MinClassBytes) << k;
    return r;
  endfunction

endpackage

FILE: hdl/slab_class_free_slot_allocator.sv
// Channel   Handshake                 Payload
// cfg       cfg_valid_i / cfg_ready_o cfg_stocked_class_i
// in        in_valid_i / in_ready_o   opcode_i, request_bytes_i, slot_in_i
// out       out_valid_o / out_ready_i status_o, class_index_o, slot_out_o,
//                                     byte_offset_o, free_slots_o, used_bytes_o
//
// One transaction is accepted per cycle unless a stalled output backs up to the input.
// The free stack is updated in the decode stage, so back-to-back pops and pushes
// see each other with no bubble; the registered stack read sets the latency.
// After reset, and after each configuration write, the stack is full in slot
// order at once; no clearing pass is needed. cfg_ready_o is always high.
// A stalled output holds its result and backs up the stages one by one.
module slab_class_free_slot_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [scfa_pkg::ClsW-1:0]     cfg_stocked_class_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [scfa_pkg::ReqW-1:0]     request_bytes_i,
  input  logic [scfa_pkg::IdxW-1:0]     slot_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [scfa_pkg::ClsW-1:0]     class_index_o,
  output logic [scfa_pkg::IdxW-1:0]     slot_out_o,
  output logic [scfa_pkg::OffW-1:0]     byte_offset_o,
  output logic [scfa_pkg::CntW-1:0]     free_slots_o,
  output logic [scfa_pkg::UsedW-1:0]    used_bytes_o
);
  import scfa_pkg::*;

  // Stage handshake.
  logic            v0_q, v1_q, v2_q;
  logic            s0_adv, s1_adv;
  logic            s1_ready, s2_ready;

  // Input register.
  logic            op0_q;
  logic [ReqW-1:0] req0_q;
  logic [IdxW-1:0] slot0_q;

  // Configuration.
  logic [ClsW-1:0] stocked_q;
  logic [ClsW-1:0] stk;
  logic [ClsW-1:0] cfg_eff;
  logic [CntW-1:0] stk_slots;

  // Decode stage.
  class_enc_t      enc;
  stack_cmd_t      cmd;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [IdxW-1:0] pop_slot;
  status_e         status_a;
  logic [ClsW-1:0] cls_a;
  logic [ShiftW-1:0] used_shamt;
  logic [UsedW-1:0]  used_prod;
  logic [UsedW-1:0]  used_a;

  // Stack read stage.
  status_e         status1_q;
  logic [ClsW-1:0] cls1_q;
  logic            grant1_q;
  logic [CntW-1:0] count1_q;
  logic [UsedW-1:0] used1_q;
  logic [IdxW-1:0] slot1;
  logic [ShiftW-1:0] off_shamt;
  logic [26:0]     off_wide;

  // Output register.
  status_e         status2_q;
  logic [ClsW-1:0] cls2_q;
  logic [IdxW-1:0] slot2_q;
  logic [OffW-1:0] off2_q;
  logic [CntW-1:0] count2_q;
  logic [UsedW-1:0] used2_q;

  assign s2_ready   = !v2_q || out_ready_i;
  assign s1_ready   = !v1_q || s2_ready;
  assign s1_adv     = v1_q && s2_ready;
  assign s0_adv     = v0_q && s1_ready;
  assign in_ready_o = !v0_q || s1_ready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      stocked_q <= StockedReset;
    end else begin
      if (in_ready_o) begin
        v0_q <= in_valid_i;
      end
      if (s1_ready) begin
        v1_q <= s0_adv;
      end
      if (s2_ready) begin
        v2_q <= s1_adv;
      end
      if (cfg_valid_i) begin
        stocked_q <= cfg_stocked_class_i;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op0_q   <= opcode_i;
      req0_q  <= request_bytes_i;
      slot0_q <= slot_in_i;
    end
  end

  assign stk       = effective_class(stocked_q);
  assign stk_slots = slots_per_page(stk);
  assign cfg_eff   = effective_class(cfg_stocked_class_i);

  scfa_class_enc u_class_enc (
    .request_bytes_i (req0_q),
    .enc_o           (enc)
  );

  // Decide the operation and the status of the item in the decode stage.
  always_comb begin
    cmd.pop  = 1'b0;
    cmd.push = 1'b0;
    cmd.slot = slot0_q;
    status_a = STATUS_OK;
    cls_a    = stk;
    if (op0_q == OP_ALLOC) begin
      cls_a = enc.cls;
      if (!enc.found) begin
        status_a = STATUS_BAD_SIZE;
      end else if ((enc.cls != stk) || (count == '0)) begin
        status_a = STATUS_NO_SLOT;
      end else begin
        cmd.pop = s0_adv;
      end
    end else begin
      if (count >= stk_slots) begin
        status_a = STATUS_OVERFLOW;
      end else begin
        cmd.push = s0_adv;
      end
    end
  end

  scfa_free_stack u_free_stack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .refill_i       (cfg_valid_i),
    .refill_count_i (slots_per_page(cfg_eff)),
    .cmd_i          (cmd),
    .count_o        (count),
    .count_next_o   (count_next),
    .slot_o         (pop_slot)
  );

  // Bytes in use after this item: page size less the free slots' bytes.
  assign used_shamt = ShiftW'(MinShift) + ShiftW'(stk);
  assign used_prod  = UsedW'(count_next) << used_shamt;
  assign used_a     = UsedW'(PageBytes) - used_prod;

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      status1_q <= status_a;
      cls1_q    <= cls_a;
      grant1_q  <= cmd.pop;
      count1_q  <= count_next;
      used1_q   <= used_a;
    end
  end

  // Granted slot and its byte offset within the page.
  assign slot1     = grant1_q ? pop_slot : '0;
  assign off_shamt = ShiftW'(MinShift) + ShiftW'(cls1_q);
  assign off_wide  = 27'(slot1) << off_shamt;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status2_q <= status1_q;
      cls2_q    <= cls1_q;
      slot2_q   <= slot1;
      off2_q    <= off_wide[OffW-1:0];
      count2_q  <= count1_q;
      used2_q   <= used1_q;
    end
  end

  assign out_valid_o   = v2_q;
  assign status_o      = status2_q;
  assign class_index_o = cls2_q;
  assign slot_out_o    = slot2_q;
  assign byte_offset_o = off2_q;
  assign free_slots_o  = count2_q;
  assign used_bytes_o  = used2_q;

`ifndef ASSERT_OFF
  // The free count never passes the slot count of the stocked class.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= stk_slots)
    else $error("free count above slots per page");

  // A pop is issued only when the stack holds a slot.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> (count != '0))
    else $error("pop from an empty free stack");

  // A pop lowers the count by one and a push raises it by one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pop && !cfg_valid_i) |=> (count == $past(count) - CntW'(1)))
    else $error("pop did not lower the free count");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push && !cfg_valid_i) |=> (count == $past(count) + CntW'(1)))
    else $error("push did not raise the free count");
`endif

endmodule

FILE: hdl/scfa_class_enc.sv
module scfa_class_enc (
  input  logic [scfa_pkg::ReqW-1:0] request_bytes_i,
  output scfa_pkg::class_enc_t      enc_o
);
  import scfa_pkg::*;

  // Smallest class that holds the request; zero or oversized is not found.
  always_comb begin
    enc_o.found = (request_bytes_i != '0) &&
                  ({1'b0, request_bytes_i} <= UsedW'(MaxClassBytes));
    enc_o.cls = '0;
    for (int k = ClassCount - 1; k >= 0; k--) begin
      if ({1'b0, request_bytes_i} <= class_bytes(ClsW'(k))) begin
        enc_o.cls = ClsW'(k);
      end
    end
    if (!enc_o.found) begin
      enc_o.cls = '0;
    end
  end

endmodule

FILE: hdl/scfa_free_stack.sv
module scfa_free_stack (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      refill_i,
  input  logic [scfa_pkg::CntW-1:0] refill_count_i,
  input  scfa_pkg::stack_cmd_t      cmd_i,
  output logic [scfa_pkg::CntW-1:0] count_o,
  output logic [scfa_pkg::CntW-1:0] count_next_o,
  output logic [scfa_pkg::IdxW-1:0] slot_o
);
  import scfa_pkg::*;

  logic [IdxW-1:0] mem_q [StackDepth];
  logic [CntW-1:0] count_q, count_d;
  // Lowest count reached since reset or the last refill. An entry below it
  // has not been pushed since then and reads as its own index.
  logic [CntW-1:0] low_q, low_d;
  logic [CntW-1:0] count_dec;
  logic [IdxW-1:0] pop_idx;
  logic [IdxW-1:0] push_idx;
  logic [IdxW-1:0] rdata_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            use_mem_q;

  assign count_dec = count_q - CntW'(1);
  assign pop_idx   = count_dec[IdxW-1:0];
  assign push_idx  = count_q[IdxW-1:0];

  // Next count and low-water mark.
  always_comb begin
    count_d = count_q;
    low_d   = low_q;
    if (refill_i) begin
      count_d = refill_count_i;
      low_d   = refill_count_i;
    end else if (cmd_i.pop) begin
      count_d = count_dec;
      if (count_dec < low_q) begin
        low_d = count_dec;
      end
    end else if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= slots_per_page(effective_class(StockedReset));
      low_q   <= slots_per_page(effective_class(StockedReset));
    end else begin
      count_q <= count_d;
      low_q   <= low_d;
    end
  end

  // Stack memory: one write port for pushes, one registered read for pops.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[push_idx] <= cmd_i.slot;
    end
    if (cmd_i.pop) begin
      rdata_q   <= mem_q[pop_idx];
      rd_idx_q  <= pop_idx;
      use_mem_q <= ({1'b0, pop_idx} >= low_q);
    end
  end

  assign count_o      = count_q;
  assign count_next_o = count_d;
  assign slot_o       = use_mem_q ? rdata_q : rd_idx_q;

endmodule
